FILE: design/wmu_pkg.sv
// Shared types and constants for the watchpoint match unit.
package wmu_pkg;

	localparam int SLOTS_DEF = 16;
	localparam int ID_W      = 31;
	localparam int ADDR_W    = 32;
	localparam int CAP_W     = 5;
	localparam int MAX_RES   = 16;

	typedef enum logic [2:0] {
		OP_ADD    = 3'd0,
		OP_REMOVE = 3'd1,
		OP_CLEAR  = 3'd2,
		OP_READ   = 3'd3,
		OP_WRITE  = 3'd4,
		OP_POLL   = 3'd5,
		OP_LIST   = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	localparam logic [1:0] KIND_READ  = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_EXEC  = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LIST,
		ST_OUT
	} state_t;

	// input item
	typedef struct packed {
		logic [CAP_W-1:0]  list_cap;
		logic [31:0]       program_counter;
		logic [7:0]        data_byte;
		logic [ID_W-1:0]   watch_id;
		logic [31:0]       span;
		logic [31:0]       address;
		logic [1:0]        watch_kind;
		logic [2:0]        operation;
	} in_item_t;

	// result item
	typedef struct packed {
		logic              last;
		logic [CAP_W-1:0]  list_count;
		logic              hit_write;
		logic [7:0]        hit_value;
		logic [31:0]       hit_pc;
		logic [31:0]       length_out;
		logic [31:0]       address_out;
		logic [1:0]        kind_out;
		logic [ID_W-1:0]   result_id;
		logic              ok;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic do_op;       // execute the captured operation, restart list scan
		logic list_step;   // examine one slot in list scan
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_list;
		logic has_result;  // captured op yields one result
		logic list_emit;   // current list slot produces an entry, or an empty scan ends
		logic list_done;   // list scan finished after this step
	} sts_t;

endpackage

FILE: design/wmu_ctrl.sv
// Controller state machine for the watchpoint match unit.
module wmu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output wmu_pkg::cmd_t  cmd,
	input  wmu_pkg::sts_t  sts
);
	import wmu_pkg::*;

	state_t state_q, state_d;
	logic   in_fire, out_fire;

	assign in_fire  = in_valid & in_ready;
	assign out_fire = out_valid & out_ready;

	// next state; list resumes after each emitted non-final entry
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (sts.is_list) state_d = ST_LIST;
					else if (sts.has_result) state_d = ST_OUT;
				end
			end
			ST_LIST: begin
				if (sts.list_emit || sts.list_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_fire)
					state_d = (sts.is_list && !sts.list_done) ? ST_LIST : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs; a list entry waits in ST_OUT, then scanning resumes unless it was the last
	always_comb begin
		in_ready        = 1'b0;
		out_valid       = 1'b0;
		cmd             = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready        = 1'b1;
				cmd.do_op       = in_fire;
			end
			ST_LIST: cmd.list_step = 1'b1;
			ST_OUT: out_valid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

endmodule

FILE: design/wmu_dp.sv
// Datapath of the watchpoint match unit: slot table, hit latch, result register.
module wmu_dp #(
	parameter int SLOTS = wmu_pkg::SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  wmu_pkg::in_item_t    in_item,
	input  wmu_pkg::cmd_t        cmd,
	output wmu_pkg::sts_t        sts,
	output wmu_pkg::out_item_t   out_item
);
	import wmu_pkg::*;

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int PW = $clog2(SLOTS + 1);

	logic [SLOTS-1:0]  used_q;
	logic [ID_W-1:0]   id_q   [SLOTS];
	logic [1:0]        kind_q [SLOTS];
	logic [31:0]       base_q [SLOTS];
	logic [31:0]       len_q  [SLOTS];
	logic [ID_W-1:0]   next_id_q;

	logic              hit_q;
	logic [1:0]        hkind_q;
	logic [31:0]       hpc_q, haddr_q, hlen_q;
	logic [7:0]        hval_q;
	logic              hwr_q;

	logic              list_q;
	logic [PW-1:0]     ptr_q;
	logic [CAP_W-1:0]  cap_q, cnt_q;
	logic              done_q;
	out_item_t         res_q, res_d;

	op_t               op;
	logic              wr;
	logic [SLOTS-1:0]  match, free, idm;
	logic [IW-1:0]     mi, fi, ri;
	logic              any_m, any_f, any_r;
	logic [CAP_W-1:0]  cap_lim, cnt_inc;
	logic [IW-1:0]     pidx;
	logic              pend, emit, fin;

	assign op = op_t'(in_item.operation);
	assign wr = (op == OP_WRITE);

	// parallel slot compare
	always_comb begin
		logic [31:0] x, e;
		for (int i = 0; i < SLOTS; i++) begin
			x = (kind_q[i] == KIND_EXEC) ? in_item.program_counter : in_item.address;
			e = base_q[i] + len_q[i];
			match[i] = used_q[i] && (x >= base_q[i]) && (x < e) &&
				!(kind_q[i] == KIND_READ && wr) && !(kind_q[i] == KIND_WRITE && !wr);
			free[i] = !used_q[i];
			idm[i]  = used_q[i] && (id_q[i] == in_item.watch_id);
		end
	end

	// first-one priority encoders
	always_comb begin
		mi = '0; fi = '0; ri = '0;
		any_m = 1'b0; any_f = 1'b0; any_r = 1'b0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (match[i]) begin mi = IW'(i); any_m = 1'b1; end
			if (free[i])  begin fi = IW'(i); any_f = 1'b1; end
			if (idm[i])   begin ri = IW'(i); any_r = 1'b1; end
		end
	end

	// list scan decisions
	assign pidx    = ptr_q[IW-1:0];
	assign pend    = (ptr_q >= PW'(SLOTS)) || (cnt_q >= cap_q);
	assign emit    = !pend && used_q[pidx];
	assign cnt_inc = cnt_q + CAP_W'(1);
	always_comb begin
		logic [PW-1:0] np;
		logic [CAP_W-1:0] nc;
		np  = ptr_q + PW'(1);
		nc  = emit ? cnt_inc : cnt_q;
		fin = pend || (np >= PW'(SLOTS)) || (nc >= cap_q);
		if (!fin) begin
			fin = 1'b1;
			for (int i = 0; i < SLOTS; i++)
				if (PW'(i) >= np && used_q[i]) fin = 1'b0;
		end
	end

	assign cap_lim = (in_item.list_cap > CAP_W'(MAX_RES)) ? CAP_W'(MAX_RES)
		: in_item.list_cap;

	assign sts.is_list    = cmd.do_op ? (op == OP_LIST) : list_q;
	assign sts.has_result = (op == OP_ADD) || (op == OP_REMOVE) || (op == OP_CLEAR)
		|| (op == OP_POLL);
	assign sts.list_emit  = emit || (fin && cnt_q == '0);
	assign sts.list_done  = done_q;
	assign out_item       = res_q;

	// slot table and hit latch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			next_id_q <= ID_W'(1);
			hit_q     <= 1'b0;
			list_q    <= 1'b0;
			done_q    <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				id_q[i] <= '0; kind_q[i] <= '0; base_q[i] <= '0; len_q[i] <= '0;
			end
		end else begin
			if (cmd.do_op) begin
				list_q <= (op == OP_LIST);
				done_q <= 1'b0;
				unique case (op)
					OP_ADD: if (any_f) begin
						used_q[fi] <= 1'b1;
						id_q[fi]   <= next_id_q;
						kind_q[fi] <= in_item.watch_kind;
						base_q[fi] <= in_item.address;
						len_q[fi]  <= (in_item.span == '0) ? 32'd1 : in_item.span;
						next_id_q  <= (next_id_q == '1) ? ID_W'(1) : next_id_q + ID_W'(1);
					end
					OP_REMOVE: if (any_r) used_q[ri] <= 1'b0;
					OP_CLEAR: used_q <= '0;
					OP_READ, OP_WRITE: if (!hit_q && any_m) hit_q <= 1'b1;
					OP_POLL: hit_q <= 1'b0;
					default: ;
				endcase
			end
			if (cmd.list_step && (emit || fin)) done_q <= fin;
		end
	end

	// next result register contents
	always_comb begin
		res_d = res_q;
		if (cmd.do_op) begin
			res_d      = '0;
			res_d.last = 1'b1;
			case (op)
				OP_ADD: begin
					res_d.ok        = any_f;
					res_d.result_id = any_f ? next_id_q : '0;
				end
				OP_REMOVE: res_d.ok = any_r;
				OP_CLEAR:  res_d.ok = 1'b1;
				OP_POLL: if (hit_q) begin
					res_d.ok          = 1'b1;
					res_d.kind_out    = hkind_q;
					res_d.address_out = haddr_q;
					res_d.length_out  = hlen_q;
					res_d.hit_pc      = hpc_q;
					res_d.hit_value   = hval_q;
					res_d.hit_write   = hwr_q;
				end
				default: ;
			endcase
		end else if (cmd.list_step) begin
			if (emit) begin
				res_d             = '0;
				res_d.ok          = 1'b1;
				res_d.result_id   = id_q[pidx];
				res_d.kind_out    = kind_q[pidx];
				res_d.address_out = base_q[pidx];
				res_d.length_out  = len_q[pidx];
				res_d.list_count  = cnt_inc;
				res_d.last        = fin;
			end else if (fin) begin
				res_d      = '0;
				res_d.last = 1'b1;
			end
		end
	end

	// hit details, list pointer and result register
	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (cmd.do_op) begin
			ptr_q <= '0;
			cnt_q <= '0;
			cap_q <= cap_lim;
			if ((op == OP_READ || op == OP_WRITE) && !hit_q && any_m) begin
				hkind_q <= kind_q[mi];
				hpc_q   <= in_item.program_counter;
				hlen_q  <= len_q[mi];
				if (kind_q[mi] == KIND_EXEC) begin
					haddr_q <= in_item.program_counter;
					hval_q  <= '0;
					hwr_q   <= 1'b0;
				end else begin
					haddr_q <= in_item.address;
					hval_q  <= in_item.data_byte;
					hwr_q   <= wr;
				end
			end
		end else if (cmd.list_step) begin
			ptr_q <= ptr_q + PW'(1);
			if (emit) cnt_q <= cnt_inc;
		end
	end

endmodule

FILE: design/watchpoint_match_unit.sv
// Top level of the watchpoint match unit.
// A table of SLOTS watch slots (read, write or execute, base and length).
// Input channel s_axis_*: one item is one operation (add, remove, clear,
// read access, write access, poll, list). Output channel m_axis_*: results.
// Add, remove, clear and poll give one result, offered in the cycle after
// acceptance; accesses give none and are compared against all slots in
// parallel in the cycle they are accepted, so a new item can follow at once.
// List walks the slots one per cycle through a scan pointer, pausing while a
// result is held, and gives one result per used slot up to the cap; with
// none listed it gives a single result with ok low. tlast marks the final
// result of an operation.
// One operation is in flight at a time: s_axis_tready is low from acceptance
// until its last result is taken. A stalled m_axis_tready holds the result.
// Reset empties the table, sets the next id to 1 and clears the hit latch.
module watchpoint_match_unit #(
	parameter int SLOTS = wmu_pkg::SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation, watch_kind, address, span, watch_id, data_byte,
	// program_counter, list_cap, 7 pad bits
	input  logic [151:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok, result_id, kind_out, address_out, length_out, hit_pc, hit_value,
	// hit_write, list_count
	output logic [143:0] m_axis_tdata,
	output logic         m_axis_tlast
);
	import wmu_pkg::*;

	in_item_t  in_item;
	out_item_t out_item;
	cmd_t      cmd;
	sts_t      sts;

	assign in_item      = s_axis_tdata[144:0];
	assign m_axis_tdata = out_item[143:0];
	assign m_axis_tlast = out_item.last;

	wmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	wmu_dp #(.SLOTS(SLOTS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

endmodule

FILE: design/wmu_checker.sv
// Port-level checker for the watchpoint match unit, bound to the top level.
module wmu_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [143:0] m_axis_tdata,
	input logic         m_axis_tlast
);
	// never take an operation while a result is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("ready with result");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed under stall");

	// final result reopens input
	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("input not reopened");

	// list count never exceeds table limit
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[143:139] <= 5'd16)
		else $error("list count too big");

	// a result only after an accepted op
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !s_axis_tready) else $error("spurious result");
endmodule

bind watchpoint_match_unit wmu_checker u_wmu_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

FILE: sim/tb_top.sv
// Self-checking testbench for the watchpoint match unit.
`timescale 1ns / 1ps

import wmu_pkg::*;

// Tracks the watch table and hit latch and holds the results still owed.
class watch_table_scoreboard;
	bit          used [16];
	bit [30:0]   ids [16];
	bit [1:0]    kinds [16];
	bit [31:0]   bases [16];
	bit [31:0]   lens [16];
	bit [30:0]   fresh_id;
	bit          hit_held;
	out_item_t   hit_info;
	out_item_t   owed [$];
	int          errors;

	function new();
		fresh_id = 1;
		hit_held = 0;
		hit_info = '0;
		errors = 0;
		foreach (used[i]) used[i] = 0;
	endfunction

	function bit covers(bit [31:0] x, bit [31:0] base, bit [31:0] len);
		bit [31:0] stop;
		stop = base + len;
		return x >= base && x < stop;
	endfunction

	// Bus access: first matching slot latches, only while no hit is held
	function void bus_access(bit [31:0] a, bit [7:0] v, bit wr, bit [31:0] pc);
		if (hit_held) return;
		for (int i = 0; i < 16; i++) begin
			if (!used[i]) continue;
			if (kinds[i] == KIND_EXEC) begin
				if (covers(pc, bases[i], lens[i])) begin
					hit_held = 1;
					hit_info = '0;
					hit_info.kind_out = KIND_EXEC;
					hit_info.address_out = pc;
					hit_info.hit_pc = pc;
					hit_info.length_out = lens[i];
					return;
				end
				continue;
			end
			if (!covers(a, bases[i], lens[i])) continue;
			if (kinds[i] == KIND_READ && wr) continue;
			if (kinds[i] == KIND_WRITE && !wr) continue;
			hit_held = 1;
			hit_info = '0;
			hit_info.kind_out = kinds[i];
			hit_info.address_out = a;
			hit_info.hit_pc = pc;
			hit_info.hit_value = v;
			hit_info.hit_write = wr;
			hit_info.length_out = lens[i];
			return;
		end
	endfunction

	// Predict the results of one accepted item
	function void note_item(in_item_t it);
		out_item_t r;
		int cap;
		int n;
		r = '0;
		r.last = 1;
		case (op_t'(it.operation))
			OP_ADD: begin
				for (int i = 0; i < 16; i++) begin
					if (!used[i]) begin
						used[i] = 1;
						ids[i] = fresh_id;
						kinds[i] = it.watch_kind;
						bases[i] = it.address;
						lens[i] = (it.span == 0) ? 32'd1 : it.span;
						r.ok = 1;
						r.result_id = fresh_id;
						fresh_id = (fresh_id == 31'h7FFF_FFFF) ? 31'd1 : fresh_id + 31'd1;
						break;
					end
				end
				owed.push_back(r);
			end
			OP_REMOVE: begin
				for (int i = 0; i < 16; i++) begin
					if (used[i] && ids[i] == it.watch_id) begin
						used[i] = 0;
						r.ok = 1;
						break;
					end
				end
				owed.push_back(r);
			end
			OP_CLEAR: begin
				for (int i = 0; i < 16; i++) begin
					used[i] = 0;
					ids[i] = 0;
					kinds[i] = 0;
					bases[i] = 0;
					lens[i] = 0;
				end
				r.ok = 1;
				owed.push_back(r);
			end
			OP_READ: bus_access(it.address, it.data_byte, 1'b0, it.program_counter);
			OP_WRITE: bus_access(it.address, it.data_byte, 1'b1, it.program_counter);
			OP_POLL: begin
				if (hit_held) begin
					r = hit_info;
					r.ok = 1;
					r.last = 1;
					hit_held = 0;
				end
				owed.push_back(r);
			end
			OP_LIST: begin
				cap = (it.list_cap > 16) ? 16 : int'(it.list_cap);
				n = 0;
				for (int i = 0; i < 16 && n < cap; i++) begin
					if (used[i]) begin
						r = '0;
						r.ok = 1;
						r.result_id = ids[i];
						r.kind_out = kinds[i];
						r.address_out = bases[i];
						r.length_out = lens[i];
						n++;
						r.list_count = 5'(n);
						owed.push_back(r);
					end
				end
				if (n == 0) begin
					r = '0;
					r.last = 1;
					owed.push_back(r);
				end else begin
					owed[owed.size()-1].last = 1;
				end
			end
			default: ;
		endcase
	endfunction

	// Compare one delivered result with the oldest prediction
	function void check_result(logic [143:0] d, logic tl);
		out_item_t got;
		out_item_t exp_r;
		got = out_item_t'({tl, d});
		if (owed.size() == 0) begin
			$display("%0t: unexpected result %h last=%b", $time, d, tl);
			errors++;
			return;
		end
		exp_r = owed.pop_front();
		if (got.ok !== exp_r.ok || got.result_id !== exp_r.result_id ||
		    got.kind_out !== exp_r.kind_out || got.address_out !== exp_r.address_out ||
		    got.length_out !== exp_r.length_out || got.hit_pc !== exp_r.hit_pc ||
		    got.hit_value !== exp_r.hit_value || got.hit_write !== exp_r.hit_write ||
		    got.list_count !== exp_r.list_count || got.last !== exp_r.last) begin
			$display("%0t: result mismatch", $time);
			$display("  ok     exp %0d got %0d", exp_r.ok, got.ok);
			$display("  id     exp %0d got %0d", exp_r.result_id, got.result_id);
			$display("  kind   exp %0d got %0d", exp_r.kind_out, got.kind_out);
			$display("  addr   exp %h got %h", exp_r.address_out, got.address_out);
			$display("  len    exp %h got %h", exp_r.length_out, got.length_out);
			$display("  pc     exp %h got %h", exp_r.hit_pc, got.hit_pc);
			$display("  value  exp %h got %h", exp_r.hit_value, got.hit_value);
			$display("  write  exp %0d got %0d", exp_r.hit_write, got.hit_write);
			$display("  count  exp %0d got %0d", exp_r.list_count, got.list_count);
			$display("  last   exp %0d got %0d", exp_r.last, got.last);
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int STALL_LIMIT = 5000;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [151:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic         m_axis_tlast;

	watch_table_scoreboard sb;
	bit  calm;
	int  idle_cycles;
	int  stall_left;
	bit [31:0] region;

	watchpoint_match_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none while calm
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task send_item(in_item_t it);
		int g;
		g = pick_gap();
		repeat (g) @(negedge clk) s_axis_tvalid = 0;
		@(negedge clk);
		s_axis_tvalid = 1;
		s_axis_tdata = {7'b0, it};
		forever begin
			@(posedge clk);
			if (s_axis_tready) break;
		end
		sb.note_item(it);
	endtask

	function in_item_t blank_item(op_t op);
		in_item_t it;
		it = '0;
		it.operation = op;
		return it;
	endfunction

	task add_watch(bit [1:0] k, bit [31:0] a, bit [31:0] s);
		in_item_t it;
		it = blank_item(OP_ADD);
		it.watch_kind = k;
		it.address = a;
		it.span = s;
		send_item(it);
	endtask

	task bus_op(op_t op, bit [31:0] a, bit [31:0] pc, bit [7:0] v);
		in_item_t it;
		it = blank_item(op);
		it.address = a;
		it.program_counter = pc;
		it.data_byte = v;
		send_item(it);
	endtask

	task list_op(bit [4:0] cap);
		in_item_t it;
		it = blank_item(OP_LIST);
		it.list_cap = cap;
		send_item(it);
	endtask

	task remove_op(bit [30:0] id);
		in_item_t it;
		it = blank_item(OP_REMOVE);
		it.watch_id = id;
		send_item(it);
	endtask

	function bit [31:0] near_addr();
		if ($urandom_range(0, 4) == 0) return $urandom();
		return region + $urandom_range(0, 63);
	endfunction

	function in_item_t random_item();
		in_item_t it;
		int r;
		it = '0;
		it.watch_kind = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		it.address = near_addr();
		r = $urandom_range(0, 9);
		if (r < 7) it.span = $urandom_range(0, 16);
		else if (r < 9) it.span = 32'hFFFF_FFFF - $urandom_range(0, 3);
		else it.span = $urandom();
		it.watch_id = ($urandom_range(0, 3) == 0) ? 31'($urandom())
			: 31'(sb.fresh_id - $urandom_range(1, 20));
		it.data_byte = 8'($urandom());
		it.program_counter = ($urandom_range(0, 1) == 0) ? near_addr() : $urandom();
		it.list_cap = 5'($urandom_range(0, 31));
		r = $urandom_range(0, 99);
		if (r < 20) it.operation = OP_ADD;
		else if (r < 30) it.operation = OP_REMOVE;
		else if (r < 50) it.operation = OP_READ;
		else if (r < 70) it.operation = OP_WRITE;
		else if (r < 84) it.operation = OP_POLL;
		else if (r < 94) it.operation = OP_LIST;
		else if (r < 97) it.operation = OP_CLEAR;
		else it.operation = OP_NONE;
		return it;
	endfunction

	// result side: random stall, now and then a long one; check at the rising edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (calm) m_axis_tready <= 1;
			else if (stall_left > 0) begin
				m_axis_tready <= 0;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 99) < 3) begin
				m_axis_tready <= 0;
				stall_left <= $urandom_range(10, 40);
			end else m_axis_tready <= ($urandom_range(0, 99) < 70);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata, m_axis_tlast);
	end

	// watchdog: cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog expired", $time);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		sb = new();
		calm = 0;
		idle_cycles = 0;
		stall_left = 0;
		region = 32'h8000_1000;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		m_axis_tready = 0;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1;

		// directed: empty table, every kind, wrap and zero span
		list_op(5'd31);
		send_item(blank_item(OP_POLL));
		remove_op(31'd0);
		add_watch(KIND_READ, 32'h0000_0000, 32'd0);
		add_watch(KIND_WRITE, 32'hFFFF_FFF0, 32'h20);
		add_watch(KIND_EXEC, 32'h0000_4000, 32'h10);
		add_watch(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_watch(KIND_WRITE, 32'h0000_0100, 32'h8);
		bus_op(OP_WRITE, 32'h0000_0000, 32'h0, 8'hFF);
		bus_op(OP_READ, 32'hFFFF_FFF5, 32'hFFFF_FFFF, 8'hAA);
		bus_op(OP_WRITE, 32'h0000_0104, 32'h0000_4008, 8'h5A);
		send_item(blank_item(OP_POLL));
		bus_op(OP_READ, 32'h0000_0000, 32'h0000_0000, 8'h81);
		send_item(blank_item(OP_POLL));
		list_op(5'd0);
		list_op(5'd2);
		remove_op(31'd3);
		remove_op(31'd3);
		send_item(blank_item(OP_NONE));
		for (int i = 0; i < 13; i++) add_watch(2'($urandom_range(0, 2)), region + i, 32'd4);
		list_op(5'd16);
		send_item(blank_item(OP_CLEAR));

		// random traffic with calm stretches
		for (int i = 0; i < 380; i++) begin
			if (i % 60 == 0) calm = ($urandom_range(0, 2) == 0);
			send_item(random_item());
		end
		@(negedge clk) s_axis_tvalid = 0;

		while (sb.owed.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

FILE: filelist.f
design/wmu_pkg.sv
design/wmu_ctrl.sv
design/wmu_dp.sv
design/watchpoint_match_unit.sv
design/wmu_checker.sv
sim/tb_top.sv
